// ===== hw/rtl/keyframe_interval_search_top_macros.svh =====
// Assertion macros shared by the keyframe interval search RTL.
`ifndef KEYFRAME_INTERVAL_SEARCH_TOP_MACROS_SVH
`define KEYFRAME_INTERVAL_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define KIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KIS_ASSERT(lbl, prop, msg)
`define KIS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/kis_pkg.sv =====
// Package with the widths, codes and interface types of the keyframe interval search block.
`default_nettype none

package kis_pkg;

  localparam int unsigned MaxKeys   = 256;
  localparam int unsigned IdxW      = $clog2(MaxKeys);
  localparam int unsigned CntW      = $clog2(MaxKeys + 1);
  localparam int unsigned TimeW     = 32;
  localparam int unsigned HintW     = 9;
  localparam int unsigned OutIdxW   = 8;
  localparam int unsigned OutcomeW  = 3;
  localparam int unsigned DiffW     = TimeW + 1;
  localparam int unsigned FracShift = 16;
  localparam int unsigned QuotW     = TimeW + 1;
  localparam int unsigned CmpW      = (HintW > CntW) ? HintW : CntW;

  localparam logic signed [TimeW-1:0] FracMax = {1'b0, {(TimeW - 1){1'b1}}};
  localparam logic signed [TimeW-1:0] FracMin = {1'b1, {(TimeW - 1){1'b0}}};

  typedef enum logic [OutcomeW-1:0] {
    OcAdded   = 3'd0,
    OcNoKeys  = 3'd1,
    OcSingle  = 3'd2,
    OcBracket = 3'd3,
    OcFull    = 3'd4
  } outcome_e;

  typedef enum logic {
    CmdAppend = 1'b0,
    CmdQuery  = 1'b1
  } command_e;

  typedef struct packed {
    logic                    start;
    logic signed [DiffW-1:0] num;
    logic signed [DiffW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [TimeW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kis_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module kis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/kis_div.sv =====
// Iterative signed 16.16 fixed-point divider with saturation, one quotient bit per cycle.
`default_nettype none
`include "keyframe_interval_search_top_macros.svh"

module kis_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kis_pkg::div_req_t req_i,
  output kis_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DvdW  = kis_pkg::DiffW + kis_pkg::FracShift;
  localparam int unsigned HiW   = DvdW - kis_pkg::QuotW;
  localparam int unsigned CntDW = $clog2(kis_pkg::QuotW);
  localparam logic [kis_pkg::QuotW-1:0] NegLim =
      kis_pkg::QuotW'(1) << (kis_pkg::TimeW - 1);
  localparam logic [kis_pkg::QuotW-1:0] PosLim = NegLim - kis_pkg::QuotW'(1);

  typedef enum logic [4:0] {
    DvIdle = 5'b00001,
    DvPrep = 5'b00010,
    DvRun  = 5'b00100,
    DvSat  = 5'b01000,
    DvFin  = 5'b10000
  } dv_state_e;

  dv_state_e state_q, state_d;

  logic                              neg_q, neg_d;
  logic                              nneg_q, nneg_d;
  logic [kis_pkg::DiffW-1:0]         nmag_q, nmag_d;
  logic [kis_pkg::DiffW-1:0]         dmag_q, dmag_d;
  logic [kis_pkg::DiffW-1:0]         rem_q, rem_d;
  logic [kis_pkg::QuotW-1:0]         dvd_q, dvd_d;
  logic [kis_pkg::QuotW-1:0]         quo_q, quo_d;
  logic [CntDW-1:0]                  cnt_q, cnt_d;
  logic signed [kis_pkg::TimeW-1:0]  res_q, res_d;

  logic [DvdW-1:0]             dividend;
  logic [HiW-1:0]              dvd_hi;
  logic [kis_pkg::DiffW:0]     shifted;
  logic [kis_pkg::DiffW+1:0]   trial;

  assign dividend = {nmag_q, {kis_pkg::FracShift{1'b0}}};
  assign dvd_hi   = dividend[DvdW-1:kis_pkg::QuotW];
  assign shifted  = {rem_q, dvd_q[kis_pkg::QuotW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dmag_q};

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    nneg_d  = nneg_q;
    nmag_d  = nmag_q;
    dmag_d  = dmag_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    case (state_q)
      DvIdle: begin
        if (req_i.start) begin
          nneg_d  = req_i.num[kis_pkg::DiffW-1];
          neg_d   = req_i.num[kis_pkg::DiffW-1] ^ req_i.den[kis_pkg::DiffW-1];
          nmag_d  = req_i.num[kis_pkg::DiffW-1] ? -req_i.num : req_i.num;
          dmag_d  = req_i.den[kis_pkg::DiffW-1] ? -req_i.den : req_i.den;
          state_d = DvPrep;
        end
      end
      DvPrep: begin
        if (dmag_q == '0) begin
          res_d   = nneg_q ? kis_pkg::FracMin : kis_pkg::FracMax;
          state_d = DvFin;
        end else if (kis_pkg::DiffW'(dvd_hi) >= dmag_q) begin
          res_d   = neg_q ? kis_pkg::FracMin : kis_pkg::FracMax;
          state_d = DvFin;
        end else begin
          rem_d   = kis_pkg::DiffW'(dvd_hi);
          dvd_d   = dividend[kis_pkg::QuotW-1:0];
          quo_d   = '0;
          cnt_d   = CntDW'(kis_pkg::QuotW - 1);
          state_d = DvRun;
        end
      end
      DvRun: begin
        if (!trial[kis_pkg::DiffW+1]) begin
          rem_d = trial[kis_pkg::DiffW-1:0];
          quo_d = {quo_q[kis_pkg::QuotW-2:0], 1'b1};
        end else begin
          rem_d = shifted[kis_pkg::DiffW-1:0];
          quo_d = {quo_q[kis_pkg::QuotW-2:0], 1'b0};
        end
        dvd_d = {dvd_q[kis_pkg::QuotW-2:0], 1'b0};
        cnt_d = cnt_q - CntDW'(1);
        if (cnt_q == '0) begin
          state_d = DvSat;
        end
      end
      DvSat: begin
        if (!neg_q) begin
          if (quo_q > PosLim) begin
            res_d = kis_pkg::FracMax;
          end else begin
            res_d = quo_q[kis_pkg::TimeW-1:0];
          end
        end else begin
          if (quo_q > NegLim) begin
            res_d = kis_pkg::FracMin;
          end else begin
            res_d = -quo_q[kis_pkg::TimeW-1:0];
          end
        end
        state_d = DvFin;
      end
      DvFin: begin
        state_d = DvIdle;
      end
      default: begin
        state_d = DvIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DvIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    nneg_q <= nneg_d;
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign rsp_o.busy = (state_q != DvIdle);
  assign rsp_o.done = (state_q == DvFin);
  assign rsp_o.quot = res_q;

  `KIS_ASSERT(a_rem_below_divisor, (state_q == DvRun) |-> (rem_q < dmag_q), "remainder not below divisor")
  `KIS_ASSERT(a_run_ends_in_sat, ((state_q == DvRun) && (cnt_q == '0)) |=> (state_q == DvSat), "quotient loop did not end")
  `KIS_ASSERT(a_fin_one_cycle, (state_q == DvFin) |=> (state_q == DvIdle), "done held for more than one cycle")

endmodule

`default_nettype wire

// ===== hw/rtl/keyframe_interval_search_top.sv =====
// Top level of the keyframe interval search: key table, hinted bracket scan and fraction.
//
//   Channel  Direction  Handshake              Payload
//   in       request    in_valid_i/in_stall_o  command_i, key_time_i, search_hint_i
//   out      result     out_valid_o/out_stall_i first_index_o, second_index_o,
//                                               fraction_o, next_hint_o, outcome_o
//
// An append, a full-table append and a query on fewer than two keys go straight to the result.
// A bracketing query scans from the hint, loads the two bracketing keys and divides unless they are equal;
// the scan reads one table entry per cycle and the divider yields one quotient bit
// per cycle, and a saturated or zero-divisor fraction skips the quotient loop.
// One request is in work at a time; a new request is taken while a result waits.
// Reset clears the key count and track length; the table needs no clearing.
// A stalled result holds in the output register until taken.
`default_nettype none
`include "keyframe_interval_search_top_macros.svh"

module keyframe_interval_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] key_time_i,
  input  logic [8:0]  search_hint_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  first_index_o,
  output logic [7:0]  second_index_o,
  output logic [31:0] fraction_o,
  output logic [7:0]  next_hint_o,
  output logic [2:0]  outcome_o
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StDisp  = 10'b0000000010,
    StScan  = 10'b0000000100,
    StLoadA = 10'b0000001000,
    StLoadB = 10'b0000010000,
    StLoadW = 10'b0000100000,
    StCalc  = 10'b0001000000,
    StStart = 10'b0010000000,
    StDiv   = 10'b0100000000,
    StEmit  = 10'b1000000000
  } kis_state_e;

  kis_state_e state_q, state_d;

  logic [kis_pkg::CntW-1:0]          count_q, count_d;
  logic signed [kis_pkg::TimeW-1:0]  track_q, track_d;

  kis_pkg::command_e                 cmd_q, cmd_d;
  logic signed [kis_pkg::TimeW-1:0]  time_q, time_d;
  logic [kis_pkg::HintW-1:0]         hint_q, hint_d;

  logic [kis_pkg::IdxW-1:0]          cur_q, cur_d;
  logic                              dir_q, dir_d;
  logic                              first_q, first_d;
  logic [kis_pkg::IdxW-1:0]          f1_q, f1_d;
  logic [kis_pkg::IdxW-1:0]          f2_q, f2_d;
  logic signed [kis_pkg::TimeW-1:0]  a_q, a_d;
  logic signed [kis_pkg::TimeW-1:0]  b_q, b_d;
  logic signed [kis_pkg::DiffW-1:0]  num_q, num_d;
  logic signed [kis_pkg::DiffW-1:0]  den_q, den_d;
  logic                              eq_q, eq_d;

  logic [kis_pkg::IdxW-1:0]          res_f1_q, res_f1_d;
  logic [kis_pkg::IdxW-1:0]          res_f2_q, res_f2_d;
  logic [kis_pkg::IdxW-1:0]          res_nh_q, res_nh_d;
  logic signed [kis_pkg::TimeW-1:0]  res_frac_q, res_frac_d;
  kis_pkg::outcome_e                 res_oc_q, res_oc_d;

  logic                              out_valid_q, out_valid_d;
  logic [kis_pkg::OutIdxW-1:0]       out_f1_q, out_f2_q, out_nh_q;
  logic signed [kis_pkg::TimeW-1:0]  out_frac_q;
  kis_pkg::outcome_e                 out_oc_q;

  logic                              mem_we;
  logic [kis_pkg::IdxW-1:0]          mem_waddr;
  logic signed [kis_pkg::TimeW-1:0]  mem_wdata;
  logic                              mem_re;
  logic [kis_pkg::IdxW-1:0]          mem_raddr;
  logic signed [kis_pkg::TimeW-1:0]  rd_data;

  kis_pkg::div_req_t                 div_req;
  kis_pkg::div_rsp_t                 div_rsp;

  logic [kis_pkg::CmpW-1:0]          hint_ext;
  logic                              hint_ok;
  logic [kis_pkg::IdxW-1:0]          start_idx;
  logic                              go_back;
  logic                              cur_last;
  logic                              f1_last;
  logic                              emit;

  assign hint_ext  = kis_pkg::CmpW'(hint_q[kis_pkg::HintW-2:0]);
  assign hint_ok   = !hint_q[kis_pkg::HintW-1] && (hint_ext < kis_pkg::CmpW'(count_q));
  assign start_idx = hint_ok ? kis_pkg::IdxW'(hint_ext) : '0;
  assign go_back   = first_q ? (rd_data >= time_q) : dir_q;
  assign cur_last  = (kis_pkg::CntW'(cur_q) + kis_pkg::CntW'(1)) == count_q;
  assign f1_last   = (kis_pkg::CntW'(f1_q) + kis_pkg::CntW'(1)) == count_q;
  assign emit      = (state_q == StEmit) && (!out_valid_q || !out_stall_i);

  kis_ram #(
    .Width (kis_pkg::TimeW),
    .Depth (kis_pkg::MaxKeys)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  kis_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    track_d    = track_q;
    cmd_d      = cmd_q;
    time_d     = time_q;
    hint_d     = hint_q;
    cur_d      = cur_q;
    dir_d      = dir_q;
    first_d    = first_q;
    f1_d       = f1_q;
    f2_d       = f2_q;
    a_d        = a_q;
    b_d        = b_q;
    num_d      = num_q;
    den_d      = den_q;
    eq_d       = eq_q;
    res_f1_d   = res_f1_q;
    res_f2_d   = res_f2_q;
    res_nh_d   = res_nh_q;
    res_frac_d = res_frac_q;
    res_oc_d   = res_oc_q;
    mem_we     = 1'b0;
    mem_waddr  = kis_pkg::IdxW'(count_q);
    mem_wdata  = time_q;
    mem_re     = 1'b0;
    mem_raddr  = cur_q;
    div_req.start = 1'b0;
    div_req.num   = num_q;
    div_req.den   = den_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_d   = kis_pkg::command_e'(command_i);
          time_d  = key_time_i;
          hint_d  = search_hint_i;
          state_d = StDisp;
        end
      end
      StDisp: begin
        res_f1_d   = '0;
        res_f2_d   = '0;
        res_nh_d   = '0;
        res_frac_d = '0;
        if (cmd_q == kis_pkg::CmdAppend) begin
          if (count_q == kis_pkg::CntW'(kis_pkg::MaxKeys)) begin
            res_oc_d = kis_pkg::OcFull;
          end else begin
            mem_we   = 1'b1;
            count_d  = count_q + kis_pkg::CntW'(1);
            if (track_q < time_q) begin
              track_d = time_q;
            end
            res_f1_d = kis_pkg::IdxW'(count_q);
            res_oc_d = kis_pkg::OcAdded;
          end
          state_d = StEmit;
        end else if (count_q == kis_pkg::CntW'(0)) begin
          res_oc_d = kis_pkg::OcNoKeys;
          state_d  = StEmit;
        end else if (count_q == kis_pkg::CntW'(1)) begin
          res_oc_d = kis_pkg::OcSingle;
          state_d  = StEmit;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = start_idx;
          cur_d     = start_idx;
          first_d   = 1'b1;
          state_d   = StScan;
        end
      end
      StScan: begin
        mem_re    = 1'b1;
        mem_raddr = go_back ? (cur_q - kis_pkg::IdxW'(1)) : (cur_q + kis_pkg::IdxW'(1));
        first_d   = 1'b0;
        dir_d     = go_back;
        if (go_back) begin
          if ((cur_q == '0) || (rd_data <= time_q)) begin
            f1_d    = cur_q;
            state_d = StLoadA;
          end else begin
            cur_d = cur_q - kis_pkg::IdxW'(1);
          end
        end else if (rd_data >= time_q) begin
          f1_d    = cur_q - kis_pkg::IdxW'(1);
          state_d = StLoadA;
        end else if (cur_last) begin
          f1_d    = cur_q;
          state_d = StLoadA;
        end else begin
          cur_d = cur_q + kis_pkg::IdxW'(1);
        end
      end
      StLoadA: begin
        mem_re    = 1'b1;
        mem_raddr = f1_q;
        f2_d      = f1_last ? f1_q : (f1_q + kis_pkg::IdxW'(1));
        state_d   = StLoadB;
      end
      StLoadB: begin
        mem_re    = 1'b1;
        mem_raddr = f2_q;
        a_d       = rd_data;
        state_d   = StLoadW;
      end
      StLoadW: begin
        b_d     = rd_data;
        state_d = StCalc;
      end
      StCalc: begin
        num_d = {time_q[kis_pkg::TimeW-1], time_q} - {a_q[kis_pkg::TimeW-1], a_q};
        if (a_q < b_q) begin
          den_d = {b_q[kis_pkg::TimeW-1], b_q} - {a_q[kis_pkg::TimeW-1], a_q};
        end else begin
          den_d = {track_q[kis_pkg::TimeW-1], track_q} - {a_q[kis_pkg::TimeW-1], a_q};
        end
        eq_d     = (a_q == b_q);
        res_f1_d = f1_q;
        res_f2_d = f2_q;
        res_nh_d = f1_q;
        res_oc_d = kis_pkg::OcBracket;
        state_d  = StStart;
      end
      StStart: begin
        if (eq_q) begin
          res_frac_d = '0;
          state_d    = StEmit;
        end else begin
          div_req.start = 1'b1;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          res_frac_d = div_rsp.quot;
          state_d    = StEmit;
        end
      end
      StEmit: begin
        if (emit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      track_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      track_q     <= track_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    time_q     <= time_d;
    hint_q     <= hint_d;
    cur_q      <= cur_d;
    dir_q      <= dir_d;
    first_q    <= first_d;
    f1_q       <= f1_d;
    f2_q       <= f2_d;
    a_q        <= a_d;
    b_q        <= b_d;
    num_q      <= num_d;
    den_q      <= den_d;
    eq_q       <= eq_d;
    res_f1_q   <= res_f1_d;
    res_f2_q   <= res_f2_d;
    res_nh_q   <= res_nh_d;
    res_frac_q <= res_frac_d;
    res_oc_q   <= res_oc_d;
    if (emit) begin
      out_f1_q   <= kis_pkg::OutIdxW'(res_f1_q);
      out_f2_q   <= kis_pkg::OutIdxW'(res_f2_q);
      out_nh_q   <= kis_pkg::OutIdxW'(res_nh_q);
      out_frac_q <= res_frac_q;
      out_oc_q   <= res_oc_q;
    end
  end

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = out_valid_q;
  assign first_index_o  = out_f1_q;
  assign second_index_o = out_f2_q;
  assign fraction_o     = out_frac_q;
  assign next_hint_o    = out_nh_q;
  assign outcome_o      = out_oc_q;

  `KIS_ASSERT(a_append_not_full, mem_we |-> (count_q != kis_pkg::CntW'(kis_pkg::MaxKeys)), "append written into a full table")
  `KIS_ASSERT(a_track_covers_key, mem_we |=> (track_q >= $past(time_q)), "track length below an appended key")
  `KIS_ASSERT(a_scan_in_range, (state_q == StScan) |-> (kis_pkg::CntW'(cur_q) < count_q), "scan cursor beyond the stored keys")
  `KIS_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider started while busy")
  `KIS_ASSERT(a_result_from_emit, $rose(out_valid_q) |-> $past(state_q == StEmit), "result raised outside the emit state")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the keyframe interval search block: directed table, random traffic.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0]         first_idx;
    logic [7:0]         second_idx;
    logic [31:0]        frac;
    logic [7:0]         next_hint;
    kis_pkg::outcome_e  oc;
  } bracket_t;

  typedef struct packed {
    kis_pkg::command_e  cmd;
    logic [31:0]        t;
    logic [8:0]         h;
    bit                 known;
    bracket_t           want;
  } stim_row_t;

  localparam int RandomCount = 700;
  localparam int IdleLimit   = 5000;
  localparam int DrainCycles = 400;
  localparam int DirCount    = 24;

  localparam bracket_t NoWant = '{8'd0, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded};

  localparam stim_row_t DirectedRows [DirCount] = '{
    '{kis_pkg::CmdQuery,  32'h0000_0000, 9'h000, 1'b1,
      '{8'd0, 8'd0, 32'h0, 8'd0, kis_pkg::OcNoKeys}},
    '{kis_pkg::CmdQuery,  32'h7FFF_FFFF, 9'h1FF, 1'b1,
      '{8'd0, 8'd0, 32'h0, 8'd0, kis_pkg::OcNoKeys}},
    '{kis_pkg::CmdAppend, 32'h0000_0000, 9'h000, 1'b1,
      '{8'd0, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded}},
    '{kis_pkg::CmdQuery,  32'h8000_0000, 9'h0FF, 1'b1,
      '{8'd0, 8'd0, 32'h0, 8'd0, kis_pkg::OcSingle}},
    '{kis_pkg::CmdAppend, 32'hFFFE_0000, 9'h1FF, 1'b1,
      '{8'd1, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded}},
    '{kis_pkg::CmdQuery,  32'hFFFF_0000, 9'h000, 1'b1,
      '{8'd0, 8'd1, 32'h8000_0000, 8'd0, kis_pkg::OcBracket}},
    '{kis_pkg::CmdQuery,  32'h0000_0000, 9'h000, 1'b1,
      '{8'd0, 8'd1, 32'h7FFF_FFFF, 8'd0, kis_pkg::OcBracket}},
    '{kis_pkg::CmdQuery,  32'h0000_0000, 9'h001, 1'b1,
      '{8'd1, 8'd1, 32'h0, 8'd1, kis_pkg::OcBracket}},
    '{kis_pkg::CmdAppend, 32'h0001_0000, 9'h000, 1'b1,
      '{8'd2, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded}},
    '{kis_pkg::CmdAppend, 32'h0003_0000, 9'h000, 1'b1,
      '{8'd3, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded}},
    '{kis_pkg::CmdQuery,  32'h0002_0000, 9'h002, 1'b1,
      '{8'd2, 8'd3, 32'h0000_8000, 8'd2, kis_pkg::OcBracket}},
    '{kis_pkg::CmdQuery,  32'h0003_0000, 9'h003, 1'b1,
      '{8'd3, 8'd3, 32'h0, 8'd3, kis_pkg::OcBracket}},
    '{kis_pkg::CmdAppend, 32'h8000_0000, 9'h000, 1'b1,
      '{8'd4, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded}},
    '{kis_pkg::CmdAppend, 32'h7FFF_FFFF, 9'h000, 1'b1,
      '{8'd5, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded}},
    '{kis_pkg::CmdAppend, 32'h0003_0000, 9'h000, 1'b1,
      '{8'd6, 8'd0, 32'h0, 8'd0, kis_pkg::OcAdded}},
    '{kis_pkg::CmdQuery,  32'h7FFF_FFFF, 9'h005, 1'b1,
      '{8'd5, 8'd6, 32'h7FFF_FFFF, 8'd5, kis_pkg::OcBracket}},
    '{kis_pkg::CmdQuery,  32'h8000_0000, 9'h1FF, 1'b0, NoWant},
    '{kis_pkg::CmdQuery,  32'h7FFF_FFFF, 9'h0FF, 1'b0, NoWant},
    '{kis_pkg::CmdQuery,  32'h0002_8000, 9'h006, 1'b0, NoWant},
    '{kis_pkg::CmdQuery,  32'h8000_0000, 9'h006, 1'b0, NoWant},
    '{kis_pkg::CmdQuery,  32'h0000_0001, 9'h1FF, 1'b0, NoWant},
    '{kis_pkg::CmdQuery,  32'hFFFF_FFFF, 9'h003, 1'b0, NoWant},
    '{kis_pkg::CmdQuery,  32'h0001_8000, 9'h000, 1'b0, NoWant},
    '{kis_pkg::CmdAppend, 32'h0003_4000, 9'h1FF, 1'b0, NoWant}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = kis_pkg::CmdAppend;
  logic [31:0] key_time_i = 32'h0;
  logic [8:0]  search_hint_i = 9'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  first_index_o;
  logic [7:0]  second_index_o;
  logic [31:0] fraction_o;
  logic [7:0]  next_hint_o;
  logic [2:0]  outcome_o;

  logic signed [31:0] key_table [kis_pkg::MaxKeys];
  int                 key_total = 0;
  logic signed [31:0] track_len = 32'sh0;

  bracket_t expected_brackets [$];
  logic [7:0] last_hint = 8'd0;
  bit  steady = 1'b0;
  int  mismatches = 0;
  int  n_checked = 0;
  int  n_appends = 0;
  int  n_full = 0;
  int  n_brackets = 0;
  int  n_sparse = 0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  keyframe_interval_search_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .key_time_i     (key_time_i),
    .search_hint_i  (search_hint_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_index_o  (first_index_o),
    .second_index_o (second_index_o),
    .fraction_o     (fraction_o),
    .next_hint_o    (next_hint_o),
    .outcome_o      (outcome_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint fixed_ratio(input longint num, input longint den);
    longint q;
    if (den == 0) begin
      return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
    end
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic bracket_t predict_bracket(input kis_pkg::command_e cmd,
                                               input logic signed [31:0] t,
                                               input logic signed [8:0] h);
    bracket_t r;
    int       pos;
    int       hi;
    longint   lo_t;
    longint   hi_t;
    longint   tq;
    r  = '0;
    tq = t;
    if (cmd == kis_pkg::CmdAppend) begin
      if (key_total >= kis_pkg::MaxKeys) begin
        r.oc = kis_pkg::OcFull;
      end else begin
        r.first_idx = 8'(key_total);
        key_table[key_total] = t;
        key_total++;
        if (track_len < t) track_len = t;
        r.oc = kis_pkg::OcAdded;
      end
    end else if (key_total == 0) begin
      r.oc = kis_pkg::OcNoKeys;
    end else if (key_total == 1) begin
      r.oc = kis_pkg::OcSingle;
    end else begin
      pos = (h < 0 || int'(h) >= key_total) ? 0 : int'(h);
      if (key_table[pos] >= t) begin
        while (pos != 0 && key_table[pos] > t) pos--;
      end else begin
        while (pos != key_total && key_table[pos] < t) pos++;
        pos--;
      end
      hi   = (pos + 1 == key_total) ? key_total - 1 : pos + 1;
      lo_t = key_table[pos];
      hi_t = key_table[hi];
      if (lo_t < hi_t) r.frac = 32'(fixed_ratio(tq - lo_t, hi_t - lo_t));
      else if (lo_t > hi_t) r.frac = 32'(fixed_ratio(tq - lo_t, longint'(track_len) - lo_t));
      else r.frac = 32'h0;
      r.first_idx  = 8'(pos);
      r.second_idx = 8'(hi);
      r.next_hint  = 8'(pos);
      r.oc         = kis_pkg::OcBracket;
    end
    return r;
  endfunction

  task automatic send_request(input kis_pkg::command_e cmd, input logic [31:0] t,
                              input logic [8:0] h, input bit known, input bracket_t want);
    int       pause;
    int       pick;
    bracket_t got;
    pick = $urandom_range(0, 99);
    if (steady) pause = 0;
    else if (pick < 55) pause = 0;
    else if (pick < 90) pause = $urandom_range(1, 3);
    else if (pick < 97) pause = $urandom_range(4, 12);
    else pause = $urandom_range(20, 60);
    repeat (pause) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    key_time_i    <= t;
    search_hint_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = predict_bracket(cmd, t, h);
    case (got.oc)
      kis_pkg::OcAdded:   n_appends++;
      kis_pkg::OcFull:    n_full++;
      kis_pkg::OcBracket: begin
        n_brackets++;
        last_hint = got.next_hint;
      end
      default:            n_sparse++;
    endcase
    expected_brackets.push_back(known ? want : got);
  endtask

  task automatic report_diff(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    bracket_t want;
    if (rst_ni && out_fire) begin
      n_checked++;
      if (expected_brackets.size() == 0) begin
        $display("%0t: result with no request waiting: outcome 0x%0h", $time, outcome_o);
        mismatches++;
      end else begin
        want = expected_brackets.pop_front();
        if (first_index_o !== want.first_idx)
          report_diff("first_index", 32'(want.first_idx), 32'(first_index_o));
        if (second_index_o !== want.second_idx)
          report_diff("second_index", 32'(want.second_idx), 32'(second_index_o));
        if (fraction_o !== want.frac)
          report_diff("fraction", want.frac, fraction_o);
        if (next_hint_o !== want.next_hint)
          report_diff("next_hint", 32'(want.next_hint), 32'(next_hint_o));
        if (outcome_o !== want.oc)
          report_diff("outcome", 32'(want.oc), 32'(outcome_o));
      end
    end
  end

  int stall_run = 0;
  int free_run = 0;

  always @(posedge clk_i) begin
    int pick;
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if (free_run > 0) begin
      out_stall_i <= 1'b0;
      free_run--;
    end else begin
      out_stall_i <= 1'b0;
      pick = $urandom_range(0, 99);
      if (steady) free_run = 10;
      else if (pick < 50) free_run = $urandom_range(0, 6);
      else if (pick < 92) stall_run = $urandom_range(1, 3);
      else stall_run = $urandom_range(20, 80);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no request or result moved for %0d cycles.", IdleLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    stim_row_t          row;
    kis_pkg::command_e  cmd;
    logic [31:0]        t;
    logic [8:0]         h;
    logic signed [31:0] rising_time;
    int                 pick;
    int                 j;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DirCount; k++) begin
      row = DirectedRows[k];
      send_request(row.cmd, row.t, row.h, row.known, row.want);
    end
    in_valid_i <= 1'b0;
    while (expected_brackets.size() != 0) @(posedge clk_i);

    rising_time = 32'sh0003_4000;
    for (int i = 0; i < RandomCount; i++) begin
      steady = (i >= 200 && i < 260);
      if (i == 350) begin
        in_valid_i <= 1'b0;
        while (expected_brackets.size() != 0) @(posedge clk_i);
      end
      pick = $urandom_range(0, 99);
      cmd  = (pick < 45) ? kis_pkg::CmdAppend : kis_pkg::CmdQuery;
      pick = $urandom_range(0, 99);
      j    = (key_total > 0) ? $urandom_range(0, key_total - 1) : 0;
      if (cmd == kis_pkg::CmdAppend) begin
        if (pick < 5) begin
          t = rising_time;
        end else if (pick < 80) begin
          rising_time = rising_time + 32'($urandom_range(1, 32'h3_0000));
          t = rising_time;
        end else if (pick < 93) begin
          t = $urandom();
        end else begin
          t = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
      end else begin
        if (key_total == 0 || pick >= 85) t = $urandom();
        else if (pick < 60) t = key_table[j] + 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
        else if (pick < 75) t = key_table[j];
        else begin
          case ($urandom_range(0, 3))
            0:       t = 32'h8000_0000;
            1:       t = 32'h7FFF_FFFF;
            2:       t = 32'h0;
            default: t = track_len;
          endcase
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) h = {1'b0, last_hint};
      else if (pick < 65) h = 9'(j);
      else if (pick < 85) h = 9'($urandom_range(0, 255));
      else if (pick < 95) h = 9'h1FF;
      else h = 9'h000;
      send_request(cmd, t, h, 1'b0, NoWant);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;
    while (expected_brackets.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results: %0d appends, %0d full-table appends, %0d bracket queries,",
             n_checked, n_appends, n_full, n_brackets);
    $display("and %0d queries on fewer than two keys; table ended with %0d keys.",
             n_sparse, key_total);
    if (mismatches == 0 && expected_brackets.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
